### rtl/sacts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_pkg: shared types and constants of the cache tag store
// Word layouts, config register codes, saturation bounds, default sizes.
// ----------------------------------------------------------------------------
package sacts_pkg;

  localparam int SETS_DEFAULT = 256;
  localparam int WAYS_DEFAULT = 4;

  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 30;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WAY_OUT_W = 2;

  localparam logic [CFG_W-1:0] OFFSET_MIN = 4'd2;
  localparam logic [CFG_W-1:0] OFFSET_MAX = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_SETS  = 2'd0,
    CFG_LOG2_BLOCK = 2'd1,
    CFG_LRU_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              fill_on_miss;
  } access_word_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 filled;
    logic                 replaced_valid;
  } result_word_t;

  // Effective (saturated) configuration
  typedef struct packed {
    logic [CFG_W-1:0] set_bits;
    logic [CFG_W-1:0] offset_bits;
    logic             lru_mode;
  } cfg_t;

  typedef struct packed {
    result_word_t result;
    logic         wr_en;
  } lookup_t;

endpackage

### rtl/set_assoc_cache_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store: set-associative tag store, LRU or FIFO
// Looks up a byte address in WAYS ways of its set; fills on a miss if fill_on_miss.
// ----------------------------------------------------------------------------
// Usage: one access word per cycle while busy is low. Assert start with cmd;
// it is taken on any edge where busy is low. The result word appears on result
// with done high for exactly one cycle, once the access has passed the stage 1
// registers and the registered set row read; there is no back-pressure, so the
// receiver must take it then. Throughput is one access per clock while busy is
// low. The result path is the registered set row read, the compare/update
// stage and the result register. After reset busy stays high while a sweep
// clears the valid bits of every set row; config writes are taken during it.
// Configuration must be written only while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store #(
  parameter int SETS = sacts_pkg::SETS_DEFAULT,
  parameter int WAYS = sacts_pkg::WAYS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // access channel
  input  logic                            start,
  output logic                            busy,
  input  sacts_pkg::access_word_t         cmd,
  // result channel
  output logic                            done,
  output sacts_pkg::result_word_t         result,
  // config write port
  input  logic                            cfg_we,
  input  logic [sacts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacts_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W  = sacts_pkg::TAG_W;
  localparam int STMP_W = sacts_pkg::STAMP_W;
  localparam int ROW_W  = WAYS * (1 + TAG_W + STMP_W);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(SETS - 1);

  sacts_pkg::cfg_t    cfg;
  sacts_pkg::state_t  state;
  sacts_pkg::lookup_t lookup;

  logic             accept;
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  // stage 0: address split
  logic [sacts_pkg::ADDR_W-1:0] shifted;
  logic [sacts_pkg::ADDR_W-1:0] set_mask;
  logic [sacts_pkg::CFG_W:0]    tag_shift;
  logic [IDX_W-1:0]             set0;
  logic [TAG_W-1:0]             tag0;

  // stage 1 registers
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_set;
  logic [TAG_W-1:0]  s1_tag;
  logic              s1_fill;
  logic [STMP_W-1:0] s1_stamp;
  logic [STMP_W-1:0] access_counter;

  // row paths
  logic             byp_sel;
  logic [ROW_W-1:0] byp_row;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] wr_row;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  logic [WAYS-1:0]             row_valid;
  logic [WAYS-1:0][TAG_W-1:0]  row_tag;
  logic [WAYS-1:0][STMP_W-1:0] row_stamp;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][TAG_W-1:0]  new_tag;
  logic [WAYS-1:0][STMP_W-1:0] new_stamp;

  sacts_cfg #(
    .SETS (SETS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // busy covers reset too, so nothing is taken on a reset edge
  assign clearing = (state == sacts_pkg::ST_CLEAR);
  assign busy     = rst || clearing;
  assign accept   = start && !busy;

  // valid-clear sweep, one set row per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sacts_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        sacts_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_ROW) begin
            state <= sacts_pkg::ST_RUN;
          end
        end
        sacts_pkg::ST_RUN: ;
        default: state <= sacts_pkg::ST_CLEAR;
      endcase
    end
  end

  // offset | set | tag, split by the saturated config
  always_comb begin
    shifted   = cmd.address >> cfg.offset_bits;
    set_mask  = (32'd1 << cfg.set_bits) - 32'd1;
    set0      = IDX_W'(shifted & set_mask);
    tag_shift = {1'b0, cfg.set_bits} + {1'b0, cfg.offset_bits};
    tag0      = TAG_W'(cmd.address >> tag_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      byp_sel        <= 1'b0;
      access_counter <= '0;
    end else begin
      s1_valid <= accept;
      // the row being written this edge is read stale by the next access
      byp_sel  <= accept && s1_valid && lookup.wr_en && (set0 == s1_set);
      if (accept) begin
        access_counter <= access_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_row <= wr_row;
    if (accept) begin
      s1_set   <= set0;
      s1_tag   <= tag0;
      s1_fill  <= cmd.fill_on_miss;
      s1_stamp <= access_counter;
    end
  end

  assign ram_we    = clearing || (s1_valid && lookup.wr_en);
  assign ram_waddr = clearing ? clr_idx : s1_set;
  assign ram_wdata = clearing ? '0 : wr_row;

  sacts_tag_ram #(
    .DEPTH (SETS),
    .ROW_W (ROW_W),
    .IDX_W (IDX_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set0),
    .rdata (rd_row)
  );

  assign cur_row = byp_sel ? byp_row : rd_row;
  assign {row_valid, row_tag, row_stamp} = cur_row;
  assign wr_row  = {new_valid, new_tag, new_stamp};

  sacts_way_select #(
    .WAYS (WAYS)
  ) u_way_select (
    .lru_mode  (cfg.lru_mode),
    .fill      (s1_fill),
    .tag       (s1_tag),
    .stamp     (s1_stamp),
    .row_valid (row_valid),
    .row_tag   (row_tag),
    .row_stamp (row_stamp),
    .lookup    (lookup),
    .new_valid (new_valid),
    .new_tag   (new_tag),
    .new_stamp (new_stamp)
  );

  // result word, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= lookup.result;
  end

endmodule

### rtl/sacts_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_cfg: configuration registers
// Holds the three config registers and presents their saturated values.
// ----------------------------------------------------------------------------
module sacts_cfg #(
  parameter int SETS = sacts_pkg::SETS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sacts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacts_pkg::CFG_W-1:0]     cfg_data,
  output sacts_pkg::cfg_t                 cfg
);

  // floor(log2(SETS))
  localparam int SET_BITS_MAX = $clog2(SETS + 1) - 1;
  localparam logic [sacts_pkg::CFG_W-1:0] SET_BITS_LIM = sacts_pkg::CFG_W'(SET_BITS_MAX);

  logic [sacts_pkg::CFG_W-1:0] log2_sets;
  logic [sacts_pkg::CFG_W-1:0] log2_block_bytes;
  logic                        lru_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_sets        <= '0;
      log2_block_bytes <= sacts_pkg::OFFSET_MIN;
      lru_mode         <= 1'b1;
    end else if (cfg_we) begin
      unique case (sacts_pkg::cfg_reg_t'(cfg_index))
        sacts_pkg::CFG_LOG2_SETS:  log2_sets        <= cfg_data;
        sacts_pkg::CFG_LOG2_BLOCK: log2_block_bytes <= cfg_data;
        sacts_pkg::CFG_LRU_MODE:   lru_mode         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.set_bits = (log2_sets > SET_BITS_LIM) ? SET_BITS_LIM : log2_sets;
    if (log2_block_bytes < sacts_pkg::OFFSET_MIN) begin
      cfg.offset_bits = sacts_pkg::OFFSET_MIN;
    end else if (log2_block_bytes > sacts_pkg::OFFSET_MAX) begin
      cfg.offset_bits = sacts_pkg::OFFSET_MAX;
    end else begin
      cfg.offset_bits = log2_block_bytes;
    end
    cfg.lru_mode = lru_mode;
  end

endmodule

### rtl/sacts_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_tag_ram: set row memory
// One row per set, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sacts_tag_ram #(
  parameter int DEPTH = sacts_pkg::SETS_DEFAULT,
  parameter int ROW_W = 8,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sacts_way_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_way_select: tag compare and victim choice
// Parallel tag compare, lowest invalid way, oldest-stamp tree, row update.
// ----------------------------------------------------------------------------
module sacts_way_select #(
  parameter int WAYS = sacts_pkg::WAYS_DEFAULT
) (
  input  logic                                       lru_mode,
  input  logic                                       fill,
  input  logic [sacts_pkg::TAG_W-1:0]                tag,
  input  logic [sacts_pkg::STAMP_W-1:0]              stamp,
  input  logic [WAYS-1:0]                            row_valid,
  input  logic [WAYS-1:0][sacts_pkg::TAG_W-1:0]      row_tag,
  input  logic [WAYS-1:0][sacts_pkg::STAMP_W-1:0]    row_stamp,
  output sacts_pkg::lookup_t                         lookup,
  output logic [WAYS-1:0]                            new_valid,
  output logic [WAYS-1:0][sacts_pkg::TAG_W-1:0]      new_tag,
  output logic [WAYS-1:0][sacts_pkg::STAMP_W-1:0]    new_stamp
);

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LEVELS = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int LEAVES = 1 << LEVELS;

  logic [WAYS-1:0]  match;
  logic             hit;
  logic             all_valid;
  logic             filled;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] sel_way;

  logic [sacts_pkg::STAMP_W-1:0] nd_stamp [LEVELS+1][LEAVES];
  logic [WAY_W-1:0]              nd_idx   [LEVELS+1][LEAVES];
  logic                          nd_en    [LEVELS+1][LEAVES];

  // compare and priority picks, lowest way wins
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_valid[w] && (row_tag[w] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    hit       = |match;
    all_valid = &row_valid;
  end

  // min-stamp tree; right child only wins when strictly smaller
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int j = 0; j < LEAVES; j++) begin
        nd_stamp[l][j] = '0;
        nd_idx[l][j]   = '0;
        nd_en[l][j]    = 1'b0;
      end
    end
    for (int i = 0; i < LEAVES; i++) begin
      if (i < WAYS) begin
        nd_stamp[0][i] = row_stamp[i];
        nd_idx[0][i]   = WAY_W'(i);
        nd_en[0][i]    = 1'b1;
      end
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int j = 0; j < LEAVES / 2; j++) begin
        if (j < (LEAVES >> l)) begin
          if (nd_en[l-1][2*j+1] &&
              (!nd_en[l-1][2*j] || (nd_stamp[l-1][2*j+1] < nd_stamp[l-1][2*j]))) begin
            nd_stamp[l][j] = nd_stamp[l-1][2*j+1];
            nd_idx[l][j]   = nd_idx[l-1][2*j+1];
            nd_en[l][j]    = 1'b1;
          end else begin
            nd_stamp[l][j] = nd_stamp[l-1][2*j];
            nd_idx[l][j]   = nd_idx[l-1][2*j];
            nd_en[l][j]    = nd_en[l-1][2*j];
          end
        end
      end
    end
    victim = nd_idx[LEVELS][0];
  end

  always_comb begin
    filled  = !hit && fill;
    sel_way = hit ? hit_way : (all_valid ? victim : inv_way);

    new_valid = row_valid;
    new_tag   = row_tag;
    new_stamp = row_stamp;
    if (filled) begin
      new_valid[sel_way] = 1'b1;
      new_tag[sel_way]   = tag;
      new_stamp[sel_way] = stamp;
    end else if (hit && lru_mode) begin
      new_stamp[sel_way] = stamp;
    end

    lookup.result.hit            = hit;
    lookup.result.way            = (hit || filled) ? sacts_pkg::WAY_OUT_W'(sel_way) : '0;
    lookup.result.filled         = filled;
    lookup.result.replaced_valid = filled && all_valid;
    lookup.wr_en                 = filled || (hit && lru_mode);
  end

endmodule

### rtl/sacts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_checker: port-level checks of the tag store
// Latency, result consistency and busy behavior, bound to the top level.
// ----------------------------------------------------------------------------
module sacts_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input sacts_pkg::result_word_t result
);

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("access word without result two cycles later");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result word without a matching access");

  a_fill_on_miss : assert property (@(posedge clk) disable iff (rst)
    (done && result.replaced_valid) |-> (result.filled && !result.hit))
    else $error("eviction reported without a fill on a miss");

  a_idle_way : assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit && !result.filled) |-> (result.way == '0))
    else $error("way nonzero on a miss without fill");

  a_busy_stays_low : assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy rose outside reset");

endmodule

bind set_assoc_cache_tag_store sacts_checker u_sacts_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
